### rtl/pft_pkg.sv
// Shared types and constants for the Pareto frontier table.
package pft_pkg;

	localparam int FIELD_W = 31;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_POP    = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_DOMINATED = 2'd1,
		STAT_EMPTY     = 2'd2,
		STAT_FULL      = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EVAL,
		S_COMPACT
	} fsm_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_SHIFT,
		CELL_REPLACE,
		CELL_COMPACT
	} cell_cmd_t;

	typedef struct packed {
		cell_cmd_t           cmd;
		logic [FIELD_W-1:0]  key_time;
		logic [FIELD_W-1:0]  key_demand;
	} cell_ctl_t;

	typedef struct packed {
		logic dom;
		logic lt;
		logic rm;
		logic at_pos;
	} cell_flag_t;

endpackage

### rtl/pft_cell.sv
// One table slot: holds a (time, demand) pair, compares it, and moves it along the chain.
module pft_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pft_pkg::cell_ctl_t            ctl,
	input  logic                          valid,
	input  logic                          left_lt,
	input  logic [pft_pkg::FIELD_W-1:0]   left_time,
	input  logic [pft_pkg::FIELD_W-1:0]   left_demand,
	input  logic                          right_del,
	input  logic [pft_pkg::FIELD_W-1:0]   right_time,
	input  logic [pft_pkg::FIELD_W-1:0]   right_demand,
	input  logic                          seen_in,
	output logic                          seen_out,
	output logic [pft_pkg::FIELD_W-1:0]   cell_time,
	output logic [pft_pkg::FIELD_W-1:0]   cell_demand,
	output logic                          del,
	output pft_pkg::cell_flag_t           flag
);

	logic [pft_pkg::FIELD_W-1:0] time_q;
	logic [pft_pkg::FIELD_W-1:0] demand_q;
	logic                        del_q;
	logic                        take_left;
	logic                        take_right;

	always_comb begin
		flag.lt     = valid & (time_q < ctl.key_time);
		flag.dom    = valid & (time_q <= ctl.key_time) & (demand_q >= ctl.key_demand);
		flag.rm     = valid & (time_q >= ctl.key_time) & (demand_q <= ctl.key_demand);
		flag.at_pos = left_lt & ~flag.lt;
	end

	assign take_left  = ~left_lt;
	assign take_right = seen_in | del_q;
	assign seen_out   = seen_in | del_q;

	always_ff @(posedge clk) begin
		case (ctl.cmd)
			pft_pkg::CELL_SHIFT: begin
				if (flag.at_pos) begin
					time_q   <= ctl.key_time;
					demand_q <= ctl.key_demand;
				end else if (take_left) begin
					time_q   <= left_time;
					demand_q <= left_demand;
				end
			end
			pft_pkg::CELL_REPLACE: begin
				if (flag.at_pos) begin
					time_q   <= ctl.key_time;
					demand_q <= ctl.key_demand;
				end
			end
			pft_pkg::CELL_COMPACT: begin
				if (take_right) begin
					time_q   <= right_time;
					demand_q <= right_demand;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			del_q <= 1'b0;
		end else begin
			case (ctl.cmd)
				pft_pkg::CELL_REPLACE: del_q <= flag.rm & ~flag.at_pos;
				pft_pkg::CELL_COMPACT: begin
					if (take_right) begin
						del_q <= right_del;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign cell_time   = time_q;
	assign cell_demand = demand_q;
	assign del         = del_q;

endmodule

### rtl/pareto_frontier_table.sv
// Pareto frontier table: sorted chain of slots with insert, dominance pruning and pop.
// The result is registered from the evaluate state, which waits while a held result is stalled.
// No new item is taken until the table is back in idle; an insert that removes more than one
// dominated entry first passes through the compact state, which closes up one slot per step.
// Reset: entry count and control state clear; slot contents stay undefined until written.
module pareto_frontier_table #(
	parameter int CAPACITY = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        operation,
	input  logic [pft_pkg::FIELD_W-1:0] new_time,
	input  logic [pft_pkg::FIELD_W-1:0] new_demand,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  status,
	output logic [pft_pkg::FIELD_W-1:0] out_time,
	output logic [pft_pkg::FIELD_W-1:0] out_demand
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int FW    = pft_pkg::FIELD_W;

	pft_pkg::fsm_t       state_q;
	pft_pkg::fsm_t       state_nxt;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    count_nxt;
	logic                op_q;
	logic [FW-1:0]       key_time_q;
	logic [FW-1:0]       key_demand_q;
	logic                out_valid_q;
	pft_pkg::status_t    status_q;
	logic [FW-1:0]       out_time_q;
	logic [FW-1:0]       out_demand_q;

	pft_pkg::cell_ctl_t  ctl;
	pft_pkg::status_t    result_status;
	logic                result_load;
	logic                go;
	logic                accept;
	logic                is_pop;

	logic [CAPACITY-1:0] slot_valid;
	logic [CAPACITY-1:0] slot_last;
	logic [CAPACITY-1:0] dom;
	logic [CAPACITY-1:0] lt;
	logic [CAPACITY-1:0] rm;
	logic [CAPACITY-1:0] del;
	logic [CAPACITY-1:0] seen;
	logic [FW-1:0]       slot_time   [CAPACITY];
	logic [FW-1:0]       slot_demand [CAPACITY];
	pft_pkg::cell_flag_t flags       [CAPACITY];

	logic                any_dom;
	logic                any_rm;
	logic                multi_rm;
	logic                multi_del;
	logic                is_empty;
	logic                is_full;
	logic [FW-1:0]       pop_time;
	logic [FW-1:0]       pop_demand;

	assign accept = in_valid & ~in_stall;
	assign go     = ~out_valid_q | ~out_stall;
	assign is_pop = (op_q == pft_pkg::OP_POP);

	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_slot
			logic          left_lt;
			logic [FW-1:0] left_time;
			logic [FW-1:0] left_demand;
			logic          right_del;
			logic [FW-1:0] right_time;
			logic [FW-1:0] right_demand;
			logic          seen_in;

			assign slot_valid[gi] = count_q > CNT_W'(gi);

			if (gi == 0) begin : g_first
				assign left_lt     = 1'b1;
				assign left_time   = '0;
				assign left_demand = '0;
				assign seen_in     = 1'b0;
			end else begin : g_mid
				assign left_lt     = lt[gi-1];
				assign left_time   = slot_time[gi-1];
				assign left_demand = slot_demand[gi-1];
				assign seen_in     = seen[gi-1];
			end

			if (gi == CAPACITY - 1) begin : g_end
				assign right_del    = 1'b0;
				assign right_time   = '0;
				assign right_demand = '0;
				assign slot_last[gi] = slot_valid[gi];
			end else begin : g_inner
				assign right_del    = del[gi+1];
				assign right_time   = slot_time[gi+1];
				assign right_demand = slot_demand[gi+1];
				assign slot_last[gi] = slot_valid[gi] & ~slot_valid[gi+1];
			end

			pft_cell u_cell (
				.clk          (clk),
				.arst_n       (arst_n),
				.ctl          (ctl),
				.valid        (slot_valid[gi]),
				.left_lt      (left_lt),
				.left_time    (left_time),
				.left_demand  (left_demand),
				.right_del    (right_del),
				.right_time   (right_time),
				.right_demand (right_demand),
				.seen_in      (seen_in),
				.seen_out     (seen[gi]),
				.cell_time    (slot_time[gi]),
				.cell_demand  (slot_demand[gi]),
				.del          (del[gi]),
				.flag         (flags[gi])
			);

			assign dom[gi] = flags[gi].dom;
			assign lt[gi]  = flags[gi].lt;
			assign rm[gi]  = flags[gi].rm;
		end
	endgenerate

	assign any_dom   = |dom;
	assign any_rm    = |rm;
	assign multi_rm  = |(rm[CAPACITY-1:1] & rm[CAPACITY-2:0]);
	assign multi_del = |(del[CAPACITY-1:1] & del[CAPACITY-2:0]);
	assign is_empty  = (count_q == '0);
	assign is_full   = (count_q == CNT_W'(CAPACITY));

	always_comb begin
		pop_time   = '0;
		pop_demand = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			pop_time   = pop_time   | ({FW{slot_last[i]}} & slot_time[i]);
			pop_demand = pop_demand | ({FW{slot_last[i]}} & slot_demand[i]);
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			pft_pkg::S_IDLE: begin
				if (accept) begin
					state_nxt = pft_pkg::S_EVAL;
				end
			end
			pft_pkg::S_EVAL: begin
				if (go) begin
					if (!is_pop && !any_dom && any_rm && multi_rm) begin
						state_nxt = pft_pkg::S_COMPACT;
					end else begin
						state_nxt = pft_pkg::S_IDLE;
					end
				end
			end
			pft_pkg::S_COMPACT: begin
				if (!multi_del) begin
					state_nxt = pft_pkg::S_IDLE;
				end
			end
			default: state_nxt = pft_pkg::S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_stall       = 1'b1;
		ctl.cmd        = pft_pkg::CELL_HOLD;
		ctl.key_time   = key_time_q;
		ctl.key_demand = key_demand_q;
		count_nxt      = count_q;
		result_load    = 1'b0;
		result_status  = pft_pkg::STAT_OK;
		case (state_q)
			pft_pkg::S_IDLE: begin
				in_stall = 1'b0;
			end
			pft_pkg::S_EVAL: begin
				if (go) begin
					result_load = 1'b1;
					if (is_pop) begin
						if (is_empty) begin
							result_status = pft_pkg::STAT_EMPTY;
						end else begin
							count_nxt = count_q - CNT_W'(1);
						end
					end else if (any_dom) begin
						result_status = pft_pkg::STAT_DOMINATED;
					end else if (is_full && !any_rm) begin
						result_status = pft_pkg::STAT_FULL;
					end else if (any_rm) begin
						ctl.cmd = pft_pkg::CELL_REPLACE;
					end else begin
						ctl.cmd   = pft_pkg::CELL_SHIFT;
						count_nxt = count_q + CNT_W'(1);
					end
				end
			end
			pft_pkg::S_COMPACT: begin
				ctl.cmd   = pft_pkg::CELL_COMPACT;
				count_nxt = count_q - CNT_W'(1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pft_pkg::S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			count_q <= count_nxt;
			if (result_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q         <= operation;
			key_time_q   <= new_time;
			key_demand_q <= new_demand;
		end
		if (result_load) begin
			status_q <= result_status;
			if (is_pop && !is_empty) begin
				out_time_q   <= pop_time;
				out_demand_q <= pop_demand;
			end else begin
				out_time_q   <= '0;
				out_demand_q <= '0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign out_time   = out_time_q;
	assign out_demand = out_demand_q;

endmodule

### bench/tb.sv
// Self-checking testbench for the Pareto frontier table: directed, full-table and random items.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 64;
	localparam int FW = pft_pkg::FIELD_W;
	localparam int PEND = 16;
	localparam int CYCLE_LIMIT = 600000;

	typedef logic [FW-1:0] field_t;

	localparam field_t FIELD_MAX = '1;

	typedef struct {
		pft_pkg::status_t code;
		field_t           t;
		field_t           d;
	} front_result_t;

	typedef enum {MIX_DENSE, MIX_CHAIN, MIX_WIDE, MIX_EDGE} mix_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               operation = 1'b0;
	field_t             new_time = '0;
	field_t             new_demand = '0;
	logic               out_stall = 1'b0;
	logic               in_stall;
	logic               out_valid;
	logic [1:0]         status;
	field_t             out_time;
	field_t             out_demand;

	// predicted table contents
	field_t             front_time [DEPTH];
	field_t             front_demand [DEPTH];
	int                 front_count = 0;

	// expected results, in order
	front_result_t expected_buf [PEND];
	int            exp_wr = 0;
	int            exp_rd = 0;
	int            errors = 0;
	int            items_sent = 0;
	int            results_seen = 0;
	int            status_count [4] = '{0, 0, 0, 0};
	int            cycles = 0;
	int            stall_left = 0;
	bit            quiet = 1'b0;

	pareto_frontier_table #(.CAPACITY(DEPTH)) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.operation  (operation),
		.new_time   (new_time),
		.new_demand (new_demand),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.out_time   (out_time),
		.out_demand (out_demand)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int draw_wait();
		return quiet ? 0 : $urandom_range(0, 10);
	endfunction

	function automatic field_t fv(input int v);
		return FW'(v);
	endfunction

	function automatic pft_pkg::status_t front_insert(input field_t t, input field_t d);
		int n = front_count;
		int pos = 0;
		int run = 0;
		for (int i = 0; i < n; i++)
			if (front_time[i] <= t && front_demand[i] >= d)
				return pft_pkg::STAT_DOMINATED;
		while (pos < n && front_time[pos] < t)
			pos++;
		while (pos + run < n && front_demand[pos + run] <= d)
			run++;
		if (n - run >= DEPTH)
			return pft_pkg::STAT_FULL;
		if (run == 0) begin
			for (int i = n; i > pos; i--) begin
				front_time[i] = front_time[i - 1];
				front_demand[i] = front_demand[i - 1];
			end
		end else begin
			for (int i = pos + 1; i + run - 1 < n; i++) begin
				front_time[i] = front_time[i + run - 1];
				front_demand[i] = front_demand[i + run - 1];
			end
		end
		front_time[pos] = t;
		front_demand[pos] = d;
		front_count = n - run + 1;
		return pft_pkg::STAT_OK;
	endfunction

	function automatic front_result_t front_apply(input pft_pkg::op_t op, input field_t t,
			input field_t d);
		front_result_t r;
		r.t = '0;
		r.d = '0;
		if (op == pft_pkg::OP_INSERT) begin
			r.code = front_insert(t, d);
		end else if (front_count == 0) begin
			r.code = pft_pkg::STAT_EMPTY;
		end else begin
			front_count--;
			r.t = front_time[front_count];
			r.d = front_demand[front_count];
			r.code = pft_pkg::STAT_OK;
		end
		return r;
	endfunction

	task automatic send_item(input pft_pkg::op_t op, input field_t t, input field_t d);
		int gap;
		gap = draw_wait();
		repeat (gap) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		new_time <= t;
		new_demand <= d;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		expected_buf[exp_wr % PEND] = front_apply(op, t, d);
		exp_wr++;
		items_sent++;
	endtask

	task automatic empty_front();
		while (front_count > 0)
			send_item(pft_pkg::OP_POP, FW'($urandom), FW'($urandom));
	endtask

	// result side: random stall per item
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			stall_left = draw_wait();
			out_stall <= (stall_left != 0);
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= (stall_left != 0);
		end
	end

	always @(posedge clk) begin
		front_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (exp_wr == exp_rd) begin
				errors++;
				$display("%0t: unexpected item, status %0d time %0d demand %0d",
					$time, status, out_time, out_demand);
			end else begin
				want = expected_buf[exp_rd % PEND];
				exp_rd++;
				results_seen++;
				status_count[int'(want.code)]++;
				if (status !== want.code) begin
					errors++;
					$display("%0t: status expected %0d actual %0d", $time, want.code, status);
				end
				if (out_time !== want.t) begin
					errors++;
					$display("%0t: out_time expected %0d actual %0d", $time, want.t, out_time);
				end
				if (out_demand !== want.d) begin
					errors++;
					$display("%0t: out_demand expected %0d actual %0d", $time, want.d, out_demand);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d items outstanding", $time, exp_wr - exp_rd);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic test_directed();
		send_item(pft_pkg::OP_POP, FIELD_MAX, FIELD_MAX);
		send_item(pft_pkg::OP_INSERT, fv(100), fv(50));
		send_item(pft_pkg::OP_INSERT, fv(200), fv(40));
		send_item(pft_pkg::OP_INSERT, fv(100), fv(50));
		send_item(pft_pkg::OP_INSERT, fv(100), fv(60));
		send_item(pft_pkg::OP_INSERT, fv(50), fv(10));
		send_item(pft_pkg::OP_INSERT, fv(150), fv(70));
		send_item(pft_pkg::OP_INSERT, fv(0), fv(0));
		send_item(pft_pkg::OP_INSERT, fv(300), fv(80));
		send_item(pft_pkg::OP_INSERT, FIELD_MAX, FIELD_MAX);
		send_item(pft_pkg::OP_INSERT, fv(120), FIELD_MAX - fv(1));
		send_item(pft_pkg::OP_INSERT, fv(0), FIELD_MAX);
		send_item(pft_pkg::OP_POP, fv(0), fv(0));
		send_item(pft_pkg::OP_POP, fv(0), fv(0));
		send_item(pft_pkg::OP_INSERT, FIELD_MAX, fv(0));
		send_item(pft_pkg::OP_POP, fv(0), fv(0));
	endtask

	task automatic test_full_table();
		empty_front();
		for (int i = 0; i < DEPTH; i++)
			send_item(pft_pkg::OP_INSERT, fv(10 * i + 10), fv(10 * i + 10));
		send_item(pft_pkg::OP_INSERT, fv(15), fv(16));
		send_item(pft_pkg::OP_INSERT, fv(15), fv(25));
		send_item(pft_pkg::OP_INSERT, fv(15), fv(25));
		send_item(pft_pkg::OP_INSERT, fv(1000), fv(5));
		send_item(pft_pkg::OP_INSERT, fv(1000), fv(1000));
		send_item(pft_pkg::OP_INSERT, fv(5), FIELD_MAX);
		send_item(pft_pkg::OP_POP, fv(0), fv(0));
		send_item(pft_pkg::OP_POP, fv(0), fv(0));
		for (int i = 0; i < DEPTH; i++)
			send_item(pft_pkg::OP_INSERT, fv(10 * i + 10), fv(10 * i + 10));
		empty_front();
		send_item(pft_pkg::OP_POP, fv(0), fv(0));
	endtask

	task automatic test_random(input int n_items);
		int           made = 0;
		int           len;
		int           pop_pct;
		mix_t         mix;
		pft_pkg::op_t op;
		field_t       t;
		field_t       d;
		while (made < n_items) begin
			mix = mix_t'($urandom_range(0, 3));
			pop_pct = (mix == MIX_CHAIN) ? $urandom_range(0, 10) : $urandom_range(5, 45);
			quiet = ($urandom_range(0, 3) == 0);
			len = $urandom_range(40, 120);
			for (int k = 0; k < len && made < n_items; k++) begin
				op = ($urandom_range(0, 99) < pop_pct) ? pft_pkg::OP_POP : pft_pkg::OP_INSERT;
				case (mix)
					MIX_DENSE: begin
						t = fv($urandom_range(0, 63));
						d = fv($urandom_range(0, 63));
					end
					MIX_CHAIN: begin
						t = fv($urandom_range(0, 100000));
						d = t + fv($urandom_range(0, 500));
					end
					MIX_WIDE: begin
						t = FW'($urandom);
						d = FW'($urandom);
					end
					default: begin
						t = ($urandom_range(0, 1) != 0) ? FIELD_MAX - fv($urandom_range(0, 40))
							: fv($urandom_range(0, 40));
						d = ($urandom_range(0, 1) != 0) ? FIELD_MAX - fv($urandom_range(0, 40))
							: fv($urandom_range(0, 40));
					end
				endcase
				send_item(op, t, d);
				made++;
			end
		end
		quiet = 1'b0;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_table();
		test_random(1200);
		in_valid <= 1'b0;
		while (exp_wr != exp_rd)
			@(posedge clk);
		repeat (80) @(posedge clk);
		$display("Sent %0d items and checked %0d results, with random gaps and stalls on both sides.",
			items_sent, results_seen);
		$display("Outcomes: %0d ok, %0d dominated, %0d pops on empty, %0d refused as full.",
			status_count[0], status_count[1], status_count[2], status_count[3]);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

### pareto_frontier_table.f
rtl/pft_pkg.sv
rtl/pft_cell.sv
rtl/pareto_frontier_table.sv
bench/tb.sv
